// ===== rtl/tricubic_patch_evaluator_macros.svh =====
// ---------------------------------------------------------------------------
// Tricubic patch evaluator assertion macros
// Concurrent checks on clk with synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef TRICUBIC_PATCH_EVALUATOR_MACROS_SVH
`define TRICUBIC_PATCH_EVALUATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define TPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tricubic_patch_evaluator: check failed");
`define TPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tricubic_patch_evaluator: sequence check failed");
`else
`define TPE_ASSERT(lbl, prop)
`define TPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tpe_pkg.sv =====
// ---------------------------------------------------------------------------
// tpe_pkg
// Shared types, constants and arithmetic helpers of the patch evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
package tpe_pkg;

  localparam int CELLS_A = 4;
  localparam int CELLS_B = 4;
  localparam int CELLS_C = 4;

  localparam int FRAC_W   = 16;
  localparam int COORD_W  = 20;
  localparam int ACC_W    = 40;
  localparam int COEF_W   = 32;
  localparam int ROW_AW   = 10;   // cell (6) + row p,q (4)

  localparam logic [COORD_W-1:0] TOP_A = COORD_W'(CELLS_A * 65536 - 1);
  localparam logic [COORD_W-1:0] TOP_B = COORD_W'(CELLS_B * 65536 - 1);
  localparam logic [COORD_W-1:0] TOP_C = COORD_W'(CELLS_C * 65536 - 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [3:0][COEF_W-1:0]   coef_row_t;

  typedef struct packed {
    logic [1:0]        p;
    logic [1:0]        q;
    logic [FRAC_W-1:0] t;
    logic [FRAC_W-1:0] u;
    logic [FRAC_W-1:0] v;
  } tag_t;

  function automatic acc_t sext(input logic [COEF_W-1:0] x);
    return {{(ACC_W-COEF_W){x[COEF_W-1]}}, x};
  endfunction

  // floor((x*f + 2^15) / 2^16)
  function automatic acc_t frac_mul(input acc_t x, input logic [FRAC_W-1:0] f);
    logic signed [ACC_W+FRAC_W:0] prod;
    prod = x * $signed({1'b0, f});
    prod = prod + (ACC_W+FRAC_W+1)'(32768);
    return prod[ACC_W+FRAC_W-1:FRAC_W];
  endfunction

  function automatic logic [31:0] sat32(input acc_t x);
    if (x[ACC_W-1:31] != {(ACC_W-31){x[ACC_W-1]}})
      return x[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpe_coef_mem.sv =====
// ---------------------------------------------------------------------------
// tpe_coef_mem
// Coefficient store: four banks, one per r, so a whole row reads at once.
// ---------------------------------------------------------------------------
`default_nettype none
module tpe_coef_mem (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [1:0]                  wr_bank,
  input  wire logic [tpe_pkg::ROW_AW-1:0]  wr_addr,
  input  wire logic [tpe_pkg::COEF_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [tpe_pkg::ROW_AW-1:0]  rd_addr,
  output tpe_pkg::coef_row_t               rd_data
);
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [tpe_pkg::COEF_W-1:0] mem [1 << tpe_pkg::ROW_AW];
    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data[b] <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tpe_row_eval.sv =====
// ---------------------------------------------------------------------------
// tpe_row_eval
// Three-stage Horner over v for one row: g = H(c, v), h = D(c, v).
// ---------------------------------------------------------------------------
`default_nettype none
module tpe_row_eval (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  tpe_pkg::tag_t       in_tag,
  input  tpe_pkg::coef_row_t  in_row,
  output logic                out_vld,
  output tpe_pkg::tag_t       out_tag,
  output tpe_pkg::acc_t       out_g,
  output tpe_pkg::acc_t       out_h
);
  logic vld1_r, vld2_r, vld3_r;
  tpe_pkg::tag_t tag1_r, tag2_r, tag3_r;
  tpe_pkg::acc_t g1_r, h1_r, g2_r, h2_r, g3_r, h3_r;
  tpe_pkg::acc_t c1_1_r, c0_1_r, c0_2_r;
  tpe_pkg::acc_t c3, c2;

  assign c3 = tpe_pkg::sext(in_row[3]);
  assign c2 = tpe_pkg::sext(in_row[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    g1_r   <= tpe_pkg::frac_mul(c3, in_tag.v) + c2;
    h1_r   <= tpe_pkg::frac_mul((c3 <<< 1) + c3, in_tag.v) + (c2 <<< 1);
    c1_1_r <= tpe_pkg::sext(in_row[1]);
    c0_1_r <= tpe_pkg::sext(in_row[0]);

    tag2_r <= tag1_r;
    g2_r   <= tpe_pkg::frac_mul(g1_r, tag1_r.v) + c1_1_r;
    h2_r   <= tpe_pkg::frac_mul(h1_r, tag1_r.v) + c1_1_r;
    c0_2_r <= c0_1_r;

    tag3_r <= tag2_r;
    g3_r   <= tpe_pkg::frac_mul(g2_r, tag2_r.v) + c0_2_r;
    h3_r   <= h2_r;
  end

  assign out_vld = vld3_r;
  assign out_tag = tag3_r;
  assign out_g   = g3_r;
  assign out_h   = h3_r;
endmodule
`default_nettype wire

// ===== rtl/tpe_u_acc.sv =====
// ---------------------------------------------------------------------------
// tpe_u_acc
// Folds rows q = 3..0 over u: G = H(g, u), Gu = D(g, u), Gv = H(h, u).
// ---------------------------------------------------------------------------
`default_nettype none
module tpe_u_acc (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_vld,
  input  tpe_pkg::tag_t   in_tag,
  input  tpe_pkg::acc_t   in_g,
  input  tpe_pkg::acc_t   in_h,
  output logic            out_vld,
  output tpe_pkg::tag_t   out_tag,
  output tpe_pkg::acc_t   out_gg,
  output tpe_pkg::acc_t   out_gu,
  output tpe_pkg::acc_t   out_gv
);
  tpe_pkg::acc_t gg_r, gu_r, gv_r, gg_nxt, gu_nxt, gv_nxt;
  logic vld_r;
  tpe_pkg::tag_t tag_r;

  always_comb begin
    gg_nxt = tpe_pkg::frac_mul(gg_r, in_tag.u) + in_g;
    gv_nxt = tpe_pkg::frac_mul(gv_r, in_tag.u) + in_h;
    gu_nxt = gu_r;
    case (in_tag.q)
      2'd3: begin
        gg_nxt = in_g;
        gu_nxt = (in_g <<< 1) + in_g;
        gv_nxt = in_h;
      end
      2'd2: gu_nxt = tpe_pkg::frac_mul(gu_r, in_tag.u) + (in_g <<< 1);
      2'd1: gu_nxt = tpe_pkg::frac_mul(gu_r, in_tag.u) + in_g;
      default: gu_nxt = gu_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld && (in_tag.q == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      gg_r  <= gg_nxt;
      gu_r  <= gu_nxt;
      gv_r  <= gv_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_vld = vld_r;
  assign out_tag = tag_r;
  assign out_gg  = gg_r;
  assign out_gu  = gu_r;
  assign out_gv  = gv_r;
endmodule
`default_nettype wire

// ===== rtl/tpe_t_acc.sv =====
// ---------------------------------------------------------------------------
// tpe_t_acc
// Folds p = 3..0 over t and saturates the four results.
// ---------------------------------------------------------------------------
`default_nettype none
module tpe_t_acc (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  tpe_pkg::tag_t      in_tag,
  input  tpe_pkg::acc_t      in_gg,
  input  tpe_pkg::acc_t      in_gu,
  input  tpe_pkg::acc_t      in_gv,
  output logic               out_vld,
  output logic [127:0]       out_data   // value, grad_a, grad_b, grad_c
);
  tpe_pkg::acc_t v_r, a_r, b_r, c_r, v_nxt, a_nxt, b_nxt, c_nxt;
  logic vld_r;
  logic [127:0] data_r;

  always_comb begin
    v_nxt = tpe_pkg::frac_mul(v_r, in_tag.t) + in_gg;
    b_nxt = tpe_pkg::frac_mul(b_r, in_tag.t) + in_gu;
    c_nxt = tpe_pkg::frac_mul(c_r, in_tag.t) + in_gv;
    a_nxt = a_r;
    case (in_tag.p)
      2'd3: begin
        v_nxt = in_gg;
        a_nxt = (in_gg <<< 1) + in_gg;
        b_nxt = in_gu;
        c_nxt = in_gv;
      end
      2'd2: a_nxt = tpe_pkg::frac_mul(a_r, in_tag.t) + (in_gg <<< 1);
      2'd1: a_nxt = tpe_pkg::frac_mul(a_r, in_tag.t) + in_gg;
      default: a_nxt = a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld && (in_tag.p == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      v_r <= v_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      data_r <= {tpe_pkg::sat32(c_nxt), tpe_pkg::sat32(b_nxt),
                 tpe_pkg::sat32(a_nxt), tpe_pkg::sat32(v_nxt)};
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;
endmodule
`default_nettype wire

// ===== rtl/tricubic_patch_evaluator.sv =====
// ---------------------------------------------------------------------------
// tricubic_patch_evaluator
// Tricubic value and gradient from per-cell coefficients, Horner pipeline.
// ---------------------------------------------------------------------------
// Load: written into the coefficient memory at the transfer, no result.
// Evaluate: 16 row reads of the coefficient memory read port; in_tready is low
//   until the last row read is issued, so the next request waits for the reads.
// Up to two evaluates may be outstanding; results queue in a 2-entry buffer.
// Reset clears the sequencer, valids and buffer; coefficients are not reset.
`default_nettype none
`include "tricubic_patch_evaluator_macros.svh"
module tricubic_patch_evaluator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,  // cell_a, cell_b, cell_c, coef_index, coef_value,
                                       // coord_a, coord_b, coord_c
  input  wire logic         in_tuser,  // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata  // value, grad_a, grad_b, grad_c
);
  logic [1:0]  cell_a, cell_b, cell_c;
  logic [5:0]  coef_index;
  logic [31:0] coef_value;
  logic [19:0] coord_a, coord_b, coord_c, ca, cb, cc;

  assign cell_a     = in_tdata[1:0];
  assign cell_b     = in_tdata[3:2];
  assign cell_c     = in_tdata[5:4];
  assign coef_index = in_tdata[11:6];
  assign coef_value = in_tdata[43:12];
  assign coord_a    = in_tdata[63:44];
  assign coord_b    = in_tdata[83:64];
  assign coord_c    = in_tdata[103:84];

  assign ca = (coord_a > tpe_pkg::TOP_A) ? tpe_pkg::TOP_A : coord_a;
  assign cb = (coord_b > tpe_pkg::TOP_B) ? tpe_pkg::TOP_B : coord_b;
  assign cc = (coord_c > tpe_pkg::TOP_C) ? tpe_pkg::TOP_C : coord_c;

  logic in_xfer, eval_acc, load_acc, out_xfer;
  logic busy_r, busy_nxt;
  logic [3:0] row_r, row_nxt;
  logic [5:0] base_r;
  logic [15:0] t_r, u_r, v_r;
  logic [1:0] pend_r, pend_nxt;

  assign in_tready = !busy_r && (pend_r != 2'd2);
  assign in_xfer   = in_tvalid && in_tready;
  assign eval_acc  = in_xfer && (in_tuser == tpe_pkg::REQ_EVAL);
  assign load_acc  = in_xfer && (in_tuser == tpe_pkg::REQ_LOAD);
  assign out_xfer  = out_tvalid && out_tready;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (eval_acc) begin
      busy_nxt = 1'b1;
      row_nxt  = 4'hF;
    end else if (busy_r) begin
      row_nxt = row_r - 4'd1;
      if (row_r == 4'd0) busy_nxt = 1'b0;
    end
    pend_nxt = pend_r + 2'(eval_acc) - 2'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= 4'd0;
      pend_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_acc) begin
      base_r <= {ca[17:16], cb[17:16], cc[17:16]};
      t_r    <= ca[15:0];
      u_r    <= cb[15:0];
      v_r    <= cc[15:0];
    end
  end

  // memory read stage
  tpe_pkg::coef_row_t rd_row;
  logic rd_vld_r;
  tpe_pkg::tag_t rd_tag_r;

  tpe_coef_mem u_mem (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_bank (coef_index[1:0]),
    .wr_addr ({cell_a, cell_b, cell_c, coef_index[5:2]}),
    .wr_data (coef_value),
    .rd_en   (busy_r),
    .rd_addr ({base_r, row_r}),
    .rd_data (rd_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= busy_r;
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= '{p: row_r[3:2], q: row_r[1:0], t: t_r, u: u_r, v: v_r};
  end

  logic r_vld, u_vld, t_vld;
  tpe_pkg::tag_t r_tag, u_tag;
  tpe_pkg::acc_t r_g, r_h, u_gg, u_gu, u_gv;
  logic [127:0] t_data;

  tpe_row_eval u_row (
    .clk (clk), .rst_n (rst_n),
    .in_vld (rd_vld_r), .in_tag (rd_tag_r), .in_row (rd_row),
    .out_vld (r_vld), .out_tag (r_tag), .out_g (r_g), .out_h (r_h)
  );

  tpe_u_acc u_uacc (
    .clk (clk), .rst_n (rst_n),
    .in_vld (r_vld), .in_tag (r_tag), .in_g (r_g), .in_h (r_h),
    .out_vld (u_vld), .out_tag (u_tag),
    .out_gg (u_gg), .out_gu (u_gu), .out_gv (u_gv)
  );

  tpe_t_acc u_tacc (
    .clk (clk), .rst_n (rst_n),
    .in_vld (u_vld), .in_tag (u_tag),
    .in_gg (u_gg), .in_gu (u_gu), .in_gv (u_gv),
    .out_vld (t_vld), .out_data (t_data)
  );

  // two-entry result buffer; outstanding count guarantees room
  logic [127:0] buf0_r, buf1_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + 2'(t_vld) - 2'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      buf0_r <= (cnt_r == 2'd2) ? buf1_r : t_data;
      if (t_vld && (cnt_r == 2'd2)) buf1_r <= t_data;
    end else if (t_vld) begin
      if (cnt_r == 2'd0) buf0_r <= t_data;
      else buf1_r <= t_data;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf0_r;

  `TPE_ASSERT(a_pend_max, pend_r != 2'd3)
  `TPE_ASSERT(a_buf_le_pend, cnt_r <= pend_r)
  `TPE_ASSERT(a_no_overflow, !(t_vld && (cnt_r == 2'd2) && !out_xfer))
  `TPE_ASSERT_NEXT(a_eval_busy, eval_acc, busy_r && (row_r == 4'hF))
endmodule
`default_nettype wire

// ===== tb/sv/tricubic_patch_evaluator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tricubic_patch_evaluator_tb
// Loads coefficient cells, evaluates value and gradient at clamped points and
// compares every result against a behavioral Horner predictor.
// ---------------------------------------------------------------------------
`default_nettype none
module tricubic_patch_evaluator_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  tricubic_patch_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  typedef logic signed [63:0] wide_t;

  logic [31:0]  coef_mem [4096];
  bit           coef_written [4096];
  logic [127:0] expected_q [$];
  int           errors;
  bit           stall_en;
  int           out_wait;

  initial begin
    clk = 1'b0;
  end
  always #1 clk = ~clk;

  // floor((x*f + 2^15) / 2^16)
  function automatic wide_t fix_mul(wide_t x, logic [15:0] f);
    wide_t y;
    y = x * $signed({48'd0, f}) + 64'sd32768;
    return y >>> 16;
  endfunction

  function automatic wide_t horner(wide_t a0, wide_t a1, wide_t a2, wide_t a3,
                                   logic [15:0] f);
    return fix_mul(fix_mul(fix_mul(a3, f) + a2, f) + a1, f) + a0;
  endfunction

  function automatic wide_t slope(wide_t a1, wide_t a2, wide_t a3, logic [15:0] f);
    return fix_mul(fix_mul(3 * a3, f) + 2 * a2, f) + a1;
  endfunction

  function automatic logic [31:0] clip32(wide_t x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [19:0] clip_coord(logic [19:0] c, logic [19:0] top);
    return (c > top) ? top : c;
  endfunction

  function automatic logic [11:0] cell_base(logic [19:0] a, logic [19:0] b,
                                            logic [19:0] c);
    return {a[17:16], b[17:16], c[17:16], 6'd0};
  endfunction

  function automatic logic [127:0] predict_patch(logic [19:0] ra, logic [19:0] rb,
                                                 logic [19:0] rc);
    logic [19:0] ca, cb, cc;
    logic [11:0] base;
    wide_t c [4];
    wide_t g [4];
    wide_t h [4];
    wide_t gp [4];
    wide_t gu [4];
    wide_t gv [4];
    ca = clip_coord(ra, tpe_pkg::TOP_A);
    cb = clip_coord(rb, tpe_pkg::TOP_B);
    cc = clip_coord(rc, tpe_pkg::TOP_C);
    base = cell_base(ca, cb, cc);
    for (int p = 0; p < 4; p++) begin
      for (int q = 0; q < 4; q++) begin
        for (int r = 0; r < 4; r++)
          c[r] = $signed(coef_mem[12'(base + p * 16 + q * 4 + r)]);
        g[q] = horner(c[0], c[1], c[2], c[3], cc[15:0]);
        h[q] = slope(c[1], c[2], c[3], cc[15:0]);
      end
      gp[p] = horner(g[0], g[1], g[2], g[3], cb[15:0]);
      gu[p] = slope(g[1], g[2], g[3], cb[15:0]);
      gv[p] = horner(h[0], h[1], h[2], h[3], cb[15:0]);
    end
    return {clip32(horner(gv[0], gv[1], gv[2], gv[3], ca[15:0])),
            clip32(horner(gu[0], gu[1], gu[2], gu[3], ca[15:0])),
            clip32(slope(gp[1], gp[2], gp[3], ca[15:0])),
            clip32(horner(gp[0], gp[1], gp[2], gp[3], ca[15:0]))};
  endfunction

  function automatic bit cell_loaded(logic [19:0] ra, logic [19:0] rb, logic [19:0] rc);
    logic [11:0] base;
    base = cell_base(clip_coord(ra, tpe_pkg::TOP_A), clip_coord(rb, tpe_pkg::TOP_B),
                     clip_coord(rc, tpe_pkg::TOP_C));
    for (int i = 0; i < 64; i++)
      if (!coef_written[12'(base + i)]) return 1'b0;
    return 1'b1;
  endfunction

  // one transfer; req_type selects load or evaluate
  // tvalid stays high after the transfer unless an idle gap follows
  task automatic send_item(logic req, logic [1:0] a, logic [1:0] b, logic [1:0] c,
                           logic [5:0] idx, logic [31:0] val,
                           logic [19:0] xa, logic [19:0] xb, logic [19:0] xc);
    int gap;
    gap = stall_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {xc, xb, xa, val, idx, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == tpe_pkg::REQ_LOAD) begin
      coef_mem[{a, b, c, idx}] = val;
      coef_written[{a, b, c, idx}] = 1'b1;
    end else begin
      expected_q.push_back(predict_patch(xa, xb, xc));
    end
  endtask

  task automatic load_cell(logic [1:0] a, logic [1:0] b, logic [1:0] c, int mode);
    logic [31:0] v;
    for (int i = 0; i < 64; i++) begin
      case (mode)
        0: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        default: v = $urandom;
      endcase
      send_item(tpe_pkg::REQ_LOAD, a, b, c, i[5:0], v,
                20'($urandom), 20'($urandom), 20'($urandom));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(0, 20'h3FFFF));
      default: return 20'($urandom);
    endcase
  endfunction

  // cells used by the directed points plus one with full-range values
  task automatic test_all_cells();
    load_cell(2'd0, 2'd0, 2'd0, 0);
    load_cell(2'd3, 2'd3, 2'd3, 0);
    load_cell(2'd3, 2'd3, 2'd0, 0);
    load_cell(2'd1, 2'd2, 2'd0, 0);
    load_cell(2'd2, 2'd1, 2'd3, 0);
    load_cell(2'd1, 2'd1, 2'd1, 3);
    drain();
  endtask

  task automatic test_directed_points();
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'd0, 20'd0, 20'd0);
    send_item(tpe_pkg::REQ_EVAL, 2'd3, 2'd3, 2'd3, 6'd63, 32'hFFFF_FFFF,
              20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h3FFFF, 20'h40000, 20'h0FFFF);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h10000, 20'h2FFFF, 20'h8000);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h0FFFF, 20'h0FFFF, 20'h0FFFF);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h2_8000, 20'h1_0001, 20'h3_7FFF);
    drain();
  endtask

  // large coefficients drive all outputs into saturation
  task automatic test_saturation();
    load_cell(2'd0, 2'd0, 2'd0, 1);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h0FFFF, 20'h0FFFF, 20'h0FFFF);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h08000, 20'd0, 20'h0C000);
    load_cell(2'd3, 2'd3, 2'd3, 2);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_item(tpe_pkg::REQ_EVAL, 2'd0, 2'd0, 2'd0, 6'd0, 32'd0,
              20'h30000, 20'h38000, 20'h3FFFF);
    drain();
  endtask

  task automatic test_random_mix(int n);
    int sent;
    logic [19:0] xa, xb, xc;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(tpe_pkg::REQ_LOAD, 2'($urandom), 2'($urandom), 2'($urandom),
                  6'($urandom), $urandom,
                  20'($urandom), 20'($urandom), 20'($urandom));
      end else begin
        xa = rand_coord(); xb = rand_coord(); xc = rand_coord();
        if (!cell_loaded(xa, xb, xc)) continue;
        send_item(tpe_pkg::REQ_EVAL, 2'($urandom), 2'($urandom), 2'($urandom),
                  6'($urandom), $urandom, xa, xb, xc);
      end
      sent++;
      if (sent == n / 2) begin
        drain();
        stall_en = 1'b0;
      end
      if (sent == 3 * n / 4) stall_en = 1'b1;
    end
    drain();
  endtask

  // each result draws its own wait before ready rises again
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        out_wait = stall_en ? $urandom_range(0, 15) : 0;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          logic [127:0] exp_r;
          exp_r = expected_q.pop_front();
          for (int f = 0; f < 4; f++)
            if (out_tdata[f*32 +: 32] !== exp_r[f*32 +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       exp_r[f*32 +: 32], out_tdata[f*32 +: 32]);
              errors++;
            end
        end
      end
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait = out_wait - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    stall_en = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_all_cells();
    test_directed_points();
    test_random_mix(400);
    test_saturation();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
